>>> sv/ipv4_header_checker_top_assert.svh
// Assertion macros for the IPv4 header checker.
// Needs clk and rst_n in the scope where a macro is used.
`ifndef IPV4_HEADER_CHECKER_TOP_ASSERT_SVH
`define IPV4_HEADER_CHECKER_TOP_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define IHC_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ipv4 header checker: same-cycle check failed");

// Consequent must hold in the cycle after the antecedent.
`define IHC_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ipv4 header checker: next-cycle check failed");

`endif

>>> sv/ihc_pkg.sv
// Types and constants for the IPv4 header checker.
// No dependencies; imported by ipv4_header_checker_top.
`default_nettype none

package ihc_pkg;

    typedef struct packed {
        logic        start_req;
        logic [7:0]  packet_byte;
        logic [15:0] frame_length;
    } ihc_in_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [5:0]  header_bytes;
        logic [15:0] payload_length;
    } ihc_out_t;

    localparam logic [2:0] STATUS_ACCEPT   = 3'd0;
    localparam logic [2:0] STATUS_VERSION  = 3'd1;
    localparam logic [2:0] STATUS_HDR_LEN  = 3'd2;
    localparam logic [2:0] STATUS_TTL      = 3'd3;
    localparam logic [2:0] STATUS_CHECKSUM = 3'd4;
    localparam logic [2:0] STATUS_DEST     = 3'd5;

    localparam logic [3:0]  IP_VERSION     = 4'd4;
    localparam logic [3:0]  MIN_IHL        = 4'd5;
    localparam logic [5:0]  TTL_OFFSET     = 6'd8;
    localparam logic [5:0]  DEST_FIRST     = 6'd16;
    localparam logic [5:0]  DEST_LAST      = 6'd19;
    localparam logic [5:0]  MIN_HDR_BYTES  = 6'd20;
    localparam logic [15:0] SUM_GOOD       = 16'hFFFF;
    localparam logic [31:0] BCAST_ADDR     = 32'hFFFF_FFFF;

endpackage

`default_nettype wire

>>> sv/ipv4_header_checker_top.sv
// IPv4 receive header checker: byte stream in, one verdict per packet out.
// Depends on ihc_pkg and ipv4_header_checker_top_assert.svh.
//
// Takes one packet byte per cycle while no verdict is held unread, with no gaps
// needed between bytes or packets. A byte is registered on acceptance and is
// parsed once the output register can advance; the verdict lands in the output
// register at the end of that cycle. Throughput is one byte per cycle, set by
// the parse stage (16-bit end-around-carry add, then the 32-bit destination
// compare). Both stages stall only while a verdict is held unread.
// Version or IHL errors are reported on byte 0; otherwise the verdict comes on
// the last header byte. local_address may only be written while no packet is
// in flight.
`default_nettype none

`include "ipv4_header_checker_top_assert.svh"

module ipv4_header_checker_top
    import ihc_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,

    input  wire logic        byte_valid,
    output      logic        byte_ready,
    input  wire ihc_in_t     byte_data,

    output      logic        verdict_valid,
    input  wire logic        verdict_ready,
    output      ihc_out_t    verdict_data,

    input  wire logic        cfg_valid,
    output      logic        cfg_ready,
    input  wire logic [31:0] cfg_data
);

    // input stage
    logic     stage_valid_reg, stage_valid_next;
    ihc_in_t  stage_data_reg;

    // parse state
    logic [31:0] local_addr_reg;
    logic [5:0]  offset_reg, offset_next;
    logic        skipping_reg, skipping_next;
    logic [3:0]  ihl_reg, ihl_next;
    logic [15:0] sum_reg, sum_next;
    logic [7:0]  high_reg, high_next;
    logic        ttl_zero_reg, ttl_zero_next;
    logic [31:0] dest_reg, dest_next;
    logic [15:0] saved_len_reg, saved_len_next;

    // result register
    logic     out_valid_reg, out_valid_next;
    ihc_out_t out_data_reg, out_data_next;

    logic        advance;
    logic        proc;
    logic        fire;
    logic [2:0]  status;
    logic [16:0] add_wide;
    logic [15:0] folded;
    logic [5:0]  last_off;
    logic [5:0]  hdr_bytes;
    logic [15:0] hdr_bytes_w;

    assign advance    = !out_valid_reg || verdict_ready;
    assign proc       = stage_valid_reg && advance;
    assign byte_ready = !stage_valid_reg || advance;
    assign cfg_ready  = 1'b1;

    assign verdict_valid = out_valid_reg;
    assign verdict_data  = out_data_reg;

    // ones'-complement add of the current word, end-around carry
    assign add_wide = {1'b0, sum_reg} + {1'b0, high_reg, stage_data_reg.packet_byte};
    assign folded   = add_wide[15:0] + {15'd0, add_wide[16]};
    assign last_off = {ihl_reg, 2'b00} - 6'd1;

    always_comb
    begin
        offset_next    = offset_reg;
        skipping_next  = skipping_reg;
        ihl_next       = ihl_reg;
        sum_next       = sum_reg;
        high_next      = high_reg;
        ttl_zero_next  = ttl_zero_reg;
        dest_next      = dest_reg;
        saved_len_next = saved_len_reg;
        fire           = 1'b0;
        status         = STATUS_ACCEPT;

        if (proc)
        begin
            if (stage_data_reg.start_req)
            begin
                saved_len_next = stage_data_reg.frame_length;
                ihl_next       = stage_data_reg.packet_byte[3:0];
                sum_next       = 16'd0;
                high_next      = stage_data_reg.packet_byte;
                ttl_zero_next  = 1'b0;
                dest_next      = 32'd0;
                offset_next    = 6'd1;
                skipping_next  = 1'b0;
                if (stage_data_reg.packet_byte[7:4] != IP_VERSION)
                begin
                    skipping_next = 1'b1;
                    fire          = 1'b1;
                    status        = STATUS_VERSION;
                end
                else if (stage_data_reg.packet_byte[3:0] < MIN_IHL)
                begin
                    skipping_next = 1'b1;
                    fire          = 1'b1;
                    status        = STATUS_HDR_LEN;
                end
            end
            else if (!skipping_reg)
            begin
                if (!offset_reg[0])
                    high_next = stage_data_reg.packet_byte;
                else
                    sum_next = folded;

                if (offset_reg == TTL_OFFSET)
                    ttl_zero_next = (stage_data_reg.packet_byte == 8'd0);
                if (offset_reg >= DEST_FIRST && offset_reg <= DEST_LAST)
                    dest_next = {dest_reg[23:0], stage_data_reg.packet_byte};

                if (offset_reg >= last_off)
                begin
                    skipping_next = 1'b1;
                    fire          = 1'b1;
                    priority if (ttl_zero_next)
                        status = STATUS_TTL;
                    else if (sum_next != SUM_GOOD)
                        status = STATUS_CHECKSUM;
                    else if (dest_next != local_addr_reg && dest_next != BCAST_ADDR)
                        status = STATUS_DEST;
                    else
                        status = STATUS_ACCEPT;
                end
                else
                begin
                    offset_next = offset_reg + 6'd1;
                end
            end
        end
    end

    assign hdr_bytes   = {ihl_next, 2'b00};
    assign hdr_bytes_w = {10'd0, hdr_bytes};

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        if (proc && fire)
        begin
            out_valid_next             = 1'b1;
            out_data_next.status       = status;
            out_data_next.header_bytes = hdr_bytes;
            out_data_next.payload_length = (saved_len_next >= hdr_bytes_w)
                                         ? (saved_len_next - hdr_bytes_w) : 16'd0;
        end
        else if (verdict_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_comb
    begin
        stage_valid_next = stage_valid_reg;
        if (byte_ready)
            stage_valid_next = byte_valid;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
            out_valid_reg   <= 1'b0;
            local_addr_reg  <= 32'd0;
            offset_reg      <= 6'd0;
            skipping_reg    <= 1'b1;
            ihl_reg         <= 4'd0;
            sum_reg         <= 16'd0;
            high_reg        <= 8'd0;
            ttl_zero_reg    <= 1'b0;
            dest_reg        <= 32'd0;
            saved_len_reg   <= 16'd0;
        end
        else
        begin
            stage_valid_reg <= stage_valid_next;
            out_valid_reg   <= out_valid_next;
            if (cfg_valid && cfg_ready)
                local_addr_reg <= cfg_data;
            offset_reg      <= offset_next;
            skipping_reg    <= skipping_next;
            ihl_reg         <= ihl_next;
            sum_reg         <= sum_next;
            high_reg        <= high_next;
            ttl_zero_reg    <= ttl_zero_next;
            dest_reg        <= dest_next;
            saved_len_reg   <= saved_len_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (byte_valid && byte_ready)
            stage_data_reg <= byte_data;
        out_data_reg <= out_data_next;
    end

    // a verdict always leaves the parser idle until the next start byte
    `IHC_ASSERT_NEXT(a_skip_after_verdict, proc && fire, skipping_reg)
    // a held byte is not lost while the verdict waits
    `IHC_ASSERT_NEXT(a_stage_holds, stage_valid_reg && !advance, stage_valid_reg)
    // late verdicts only come from headers of at least twenty bytes
    `IHC_ASSERT_SAME(a_late_hdr_len,
        verdict_valid && verdict_data.status != STATUS_VERSION
            && verdict_data.status != STATUS_HDR_LEN,
        verdict_data.header_bytes >= MIN_HDR_BYTES)
    // a header length error means a short IHL
    `IHC_ASSERT_SAME(a_short_hdr,
        verdict_valid && verdict_data.status == STATUS_HDR_LEN,
        verdict_data.header_bytes < MIN_HDR_BYTES)

endmodule

`default_nettype wire

>>> tb/tb_ipv4_header_checker_top.sv
// Self-checking testbench for ipv4_header_checker_top: byte-stream stimulus, verdict scoreboard.
// Needs ihc_pkg and the checker RTL; the expected verdicts come from an in-bench header parser.
`timescale 1ns / 100ps

module tb_ipv4_header_checker_top;
    import ihc_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int SETTLE_CYCLES  = 8;
    localparam int PHASE_ITEMS    = 340;
    localparam int REPORT_LIMIT   = 10;

    logic        clk           = 1'b0;
    logic        rst_n         = 1'b0;
    logic        byte_valid    = 1'b0;
    logic        byte_ready;
    ihc_in_t     byte_data     = '0;
    logic        verdict_valid;
    logic        verdict_ready = 1'b0;
    ihc_out_t    verdict_data;
    logic        cfg_valid     = 1'b0;
    logic        cfg_ready;
    logic [31:0] cfg_data      = '0;

    ihc_in_t     byte_backlog[$];
    ihc_out_t    verdicts_due[$];
    int          sender_idle_pct = 0;
    int          ready_stall_pct = 0;
    int          bad_verdicts    = 0;
    int          quiet_cycles    = 0;
    int          stim_items      = 0;
    logic [31:0] cfg_setting     = '0;

    // Header parser state, mirrors what the block should hold
    logic [31:0] local_addr  = '0;
    logic [5:0]  hdr_offset  = '0;
    logic        hunting     = 1'b1;
    logic [3:0]  hdr_ihl     = '0;
    logic [15:0] csum_acc    = '0;
    logic [7:0]  word_hi     = '0;
    logic        ttl_expired = 1'b0;
    logic [31:0] dest_ip     = '0;
    logic [15:0] frame_len   = '0;

    ipv4_header_checker_top DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .byte_valid    (byte_valid),
        .byte_ready    (byte_ready),
        .byte_data     (byte_data),
        .verdict_valid (verdict_valid),
        .verdict_ready (verdict_ready),
        .verdict_data  (verdict_data),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic logic [15:0] ones_add(input logic [15:0] a, input logic [15:0] b);
        logic [16:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[15:0] + {15'd0, s[16]};
    endfunction

    function automatic ihc_out_t make_verdict(input logic [2:0] code);
        ihc_out_t   v;
        logic [5:0] hb;
        hb               = {hdr_ihl, 2'b00};
        v.status         = code;
        v.header_bytes   = hb;
        // payload length saturates at zero on short frames
        v.payload_length = (frame_len >= {10'd0, hb}) ? frame_len - {10'd0, hb} : 16'd0;
        return v;
    endfunction

    task automatic parse_header_byte(input ihc_in_t t);
        logic [7:0] b;
        logic [5:0] last;
        logic [2:0] code;
        b = t.packet_byte;
        if (t.start_req)
        begin
            frame_len   = t.frame_length;
            hdr_ihl     = b[3:0];
            csum_acc    = '0;
            word_hi     = b;
            ttl_expired = 1'b0;
            dest_ip     = '0;
            hdr_offset  = 6'd1;
            hunting     = 1'b0;
            if (b[7:4] != IP_VERSION)
            begin
                hunting = 1'b1;
                verdicts_due.push_back(make_verdict(STATUS_VERSION));
            end
            else if (b[3:0] < MIN_IHL)
            begin
                hunting = 1'b1;
                verdicts_due.push_back(make_verdict(STATUS_HDR_LEN));
            end
        end
        else if (!hunting)
        begin
            if (!hdr_offset[0])
                word_hi = b;
            else
                csum_acc = ones_add(csum_acc, {word_hi, b});
            if (hdr_offset == TTL_OFFSET)
                ttl_expired = (b == 8'd0);
            if (hdr_offset >= DEST_FIRST && hdr_offset <= DEST_LAST)
                dest_ip = {dest_ip[23:0], b};
            last = {hdr_ihl, 2'b00} - 6'd1;
            if (hdr_offset >= last)
            begin
                hunting = 1'b1;
                if (ttl_expired)
                    code = STATUS_TTL;
                else if (csum_acc != SUM_GOOD)
                    code = STATUS_CHECKSUM;
                else if (dest_ip != local_addr && dest_ip != BCAST_ADDR)
                    code = STATUS_DEST;
                else
                    code = STATUS_ACCEPT;
                verdicts_due.push_back(make_verdict(code));
            end
            else
                hdr_offset = hdr_offset + 6'd1;
        end
    endtask

    task automatic compare_verdict(input ihc_out_t got);
        ihc_out_t want;
        if (verdicts_due.size() == 0)
        begin
            bad_verdicts++;
            if (bad_verdicts <= REPORT_LIMIT)
                $display("unexpected verdict: status %0d hdr %0d payload %0d",
                         got.status, got.header_bytes, got.payload_length);
        end
        else
        begin
            want = verdicts_due.pop_front();
            if (got.status !== want.status || got.header_bytes !== want.header_bytes ||
                got.payload_length !== want.payload_length)
            begin
                bad_verdicts++;
                if (bad_verdicts <= REPORT_LIMIT)
                    $display("verdict mismatch: expected %0d/%0d/%0d, got %0d/%0d/%0d",
                             want.status, want.header_bytes, want.payload_length,
                             got.status, got.header_bytes, got.payload_length);
            end
        end
    endtask

    // Builds one packet; cut keeps only the first bytes, tail adds payload bytes.
    task automatic queue_packet(input logic [3:0] ver, input logic [3:0] ihl,
                                input logic [7:0] ttl, input bit sum_ok,
                                input logic [31:0] dst, input logic [15:0] flen,
                                input int cut, input int tail);
        logic [7:0]  hdr [60];
        logic [15:0] s;
        logic [15:0] ck;
        ihc_in_t     t;
        int          n;
        int          keep;
        int          i;
        n = (ihl < MIN_IHL) ? int'(MIN_HDR_BYTES) : int'(ihl) * 4;
        for (i = 0; i < n; i++)
            hdr[i] = 8'($urandom);
        hdr[0]  = {ver, ihl};
        hdr[8]  = ttl;
        hdr[10] = 8'd0;
        hdr[11] = 8'd0;
        hdr[16] = dst[31:24];
        hdr[17] = dst[23:16];
        hdr[18] = dst[15:8];
        hdr[19] = dst[7:0];
        s = '0;
        for (i = 0; i < n; i += 2)
            s = ones_add(s, {hdr[i], hdr[i + 1]});
        ck = ~s;
        if (!sum_ok)
            ck = ck ^ 16'($urandom_range(1, 16'hFFFF));
        hdr[10] = ck[15:8];
        hdr[11] = ck[7:0];
        keep = (cut > 0 && cut < n) ? cut : n;
        for (i = 0; i < keep; i++)
        begin
            t.start_req    = (i == 0);
            t.packet_byte  = hdr[i];
            t.frame_length = (i == 0) ? flen : 16'($urandom);
            byte_backlog.push_back(t);
        end
        for (i = 0; i < tail; i++)
        begin
            t.start_req    = 1'b0;
            t.packet_byte  = 8'($urandom);
            t.frame_length = 16'($urandom);
            byte_backlog.push_back(t);
        end
        stim_items += (ver != IP_VERSION || ihl < MIN_IHL) ? 1 : keep;
    endtask

    task automatic random_packet();
        logic [3:0]  ihl;
        logic [3:0]  ver;
        logic [7:0]  ttl;
        logic [31:0] dst;
        logic [15:0] flen;
        ihc_in_t     t;
        int          r;
        int          pick;
        int          i;
        r    = $urandom_range(99);
        pick = $urandom_range(99);
        ihl  = ($urandom_range(99) < 80) ? MIN_IHL : 4'($urandom_range(6, 15));
        ttl  = ($urandom_range(9) == 0) ? 8'd0 : 8'($urandom_range(1, 255));
        dst  = (pick < 60) ? cfg_setting : (pick < 75) ? BCAST_ADDR : 32'($urandom);
        flen = ($urandom_range(2) == 0) ? 16'($urandom_range(0, 80)) : 16'($urandom);
        if (r < 72)
            queue_packet(IP_VERSION, ihl, ttl, $urandom_range(99) < 85, dst, flen, 0,
                         $urandom_range(0, 6));
        else if (r < 82)
            // header cut short, the next start byte restarts parsing
            queue_packet(IP_VERSION, ihl, ttl, 1'b1, dst, flen,
                         $urandom_range(1, int'(ihl) * 4 - 1), 0);
        else if (r < 92)
        begin
            if ($urandom_range(1) == 1)
            begin
                ver = 4'($urandom_range(0, 14));
                if (ver >= IP_VERSION)
                    ver = ver + 4'd1;
                queue_packet(ver, 4'($urandom), ttl, 1'b1, dst, flen, 1, $urandom_range(0, 3));
            end
            else
                queue_packet(IP_VERSION, 4'($urandom_range(0, 4)), ttl, 1'b1, dst, flen, 1,
                             $urandom_range(0, 3));
        end
        else
        begin
            for (i = 0; i < int'($urandom_range(1, 4)); i++)
            begin
                t.start_req    = ($urandom_range(3) == 0);
                t.packet_byte  = 8'($urandom);
                t.frame_length = 16'($urandom);
                byte_backlog.push_back(t);
            end
        end
    endtask

    task automatic write_local(input logic [31:0] value);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    task automatic wait_drained();
        do
            @(posedge clk);
        while (byte_backlog.size() != 0 || byte_valid || verdicts_due.size() != 0);
        // trailing bytes may still be in the pipe without a verdict
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Byte driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_valid <= 1'b0;
            byte_data  <= '0;
        end
        else if (!byte_valid || byte_ready)
        begin
            if (byte_backlog.size() != 0 && $urandom_range(99) >= sender_idle_pct)
            begin
                byte_data  <= byte_backlog.pop_front();
                byte_valid <= 1'b1;
            end
            else
                byte_valid <= 1'b0;
        end
    end

    // Verdict receiver back-pressure
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            verdict_ready <= 1'b0;
        else
            verdict_ready <= ($urandom_range(99) >= ready_stall_pct);
    end

    // Monitor: tracks every transaction, feeds the parser and checks verdicts
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (verdict_valid && verdict_ready)
                compare_verdict(verdict_data);
            if (cfg_valid && cfg_ready)
                local_addr = cfg_data;
            if (byte_valid && byte_ready)
                parse_header_byte(byte_data);
            if ((verdict_valid && verdict_ready) || (cfg_valid && cfg_ready) ||
                (byte_valid && byte_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    initial
    begin
        ihc_in_t stray;
        int      ph;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        for (ph = 0; ph < 4; ph++)
        begin
            case (ph)
                0: cfg_setting = 32'h0;
                2: cfg_setting = BCAST_ADDR;
                default: cfg_setting = 32'($urandom);
            endcase
            write_local(cfg_setting);
            sender_idle_pct = (ph == 1) ? 81 : (ph == 3) ? 15 : 0;
            ready_stall_pct = (ph == 2) ? 81 : (ph == 3) ? 15 : 0;
            if (ph == 0)
            begin
                // byte with no packet open is dropped
                stray.start_req    = 1'b0;
                stray.packet_byte  = 8'hFF;
                stray.frame_length = 16'hFFFF;
                byte_backlog.push_back(stray);
                queue_packet(4'hF, 4'hF, 8'd0, 1'b1, 32'h0, 16'h0000, 1, 0);
                queue_packet(4'h0, 4'h0, 8'd0, 1'b1, 32'h0, 16'hFFFF, 1, 0);
                queue_packet(IP_VERSION, 4'd4, 8'd0, 1'b1, 32'h0, 16'd3, 1, 0);
                queue_packet(IP_VERSION, 4'd0, 8'd0, 1'b1, 32'h0, 16'hFFFF, 1, 0);
                queue_packet(4'd6, MIN_IHL, 8'd0, 1'b1, 32'h0, 16'd100, 1, 0);
                queue_packet(IP_VERSION, MIN_IHL, 8'd255, 1'b1, BCAST_ADDR, 16'd20, 0, 1);
            end
            stim_items = 0;
            while (stim_items < PHASE_ITEMS)
                random_packet();
            // complete packet so the parser is idle before the next register write
            queue_packet(IP_VERSION, MIN_IHL, 8'd64, 1'b1, cfg_setting, 16'($urandom), 0, 0);
            wait_drained();
        end
        if (bad_verdicts == 0 && verdicts_due.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
